### sv/ssp_pkg.sv
// ---------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the sorted slotted page directory
// Holds the page geometry, the command and status codes and the slot entry
// type that travels along the chain of directory cells.
// ---------------------------------------------------------------------------
package ssp_pkg;

    // Page geometry; the 12-bit offset and length fields fix these.
    localparam int PAGE_BYTES      = 4096;
    localparam int HEAD_BYTES      = 32;
    localparam int REC_IDX_LEN     = 2;
    localparam int MAX_RECORDS_DEF = 256;

    // Command codes carried in the input tuser.
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Status codes carried in the output tuser.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EXISTS  = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    // One directory entry.
    typedef struct packed {
        logic [11:0] off;
        logic [11:0] len;
        logic [63:0] key;
    } slot_t;

    // One result transfer.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [11:0] off;
        logic [11:0] len;
        logic [63:0] key;
        logic        replaced;
        logic        compacted;
        logic [8:0]  count;
        logic [11:0] free;
        logic [11:0] garbage;
    } res_t;

endpackage

### sv/ssp_cell.sv
// ---------------------------------------------------------------------------
// ssp_cell: one directory cell
// Holds one slot entry and loads its neighbor's entry when the ring shifts.
// ---------------------------------------------------------------------------
module ssp_cell
    import ssp_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  slot_t d,
    output slot_t q
);

    slot_t entry_reg;

    // Entry contents are undefined until written, so no reset.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

### sv/ssp_ring.sv
// ---------------------------------------------------------------------------
// ssp_ring: circular chain of directory cells
// Cell k takes cell k+1 on a shift; the last cell takes the entry that the
// head logic returns, so one full rotation visits every slot in order.
// ---------------------------------------------------------------------------
module ssp_ring
    import ssp_pkg::*;
#(
    parameter int DEPTH = MAX_RECORDS_DEF
)
(
    input  logic  clk,
    input  logic  shift,
    input  slot_t tail,
    output slot_t head
);

    slot_t chain [DEPTH+1];

    // The returned entry enters at the far end of the chain.
    assign chain[DEPTH] = tail;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        ssp_cell u_cell
        (
            .clk   (clk),
            .shift (shift),
            .d     (chain[k+1]),
            .q     (chain[k])
        );
    end

    assign head = chain[0];

endmodule

### sv/sorted_slotted_page_directory.sv
// ---------------------------------------------------------------------------
// sorted_slotted_page_directory: timestamp-ordered slot directory of a page
// Keeps offset, length and key of every record in key order, plus record
// count, free bytes and garbage bytes; handles clear, insert and read.
// ---------------------------------------------------------------------------
//
// Channel  Dir  Signals                       Contents
// s_axis   in   tvalid tready tdata tuser     command and record to insert
// m_axis   out  tvalid tready tdata tuser     status, slot and page counters
//
// Clear and unused commands go straight to the result state. A read takes
// one rotation of the cell ring. An insert takes up to three rotations:
// an optional compaction rotation, a search rotation and a write rotation,
// one slot passing the head logic per cycle.
// Reset clears the counters; cell contents are undefined until written.
// A stalled result waits in the output register while the next command is
// taken in; that command's result waits until the register is free.
// ---------------------------------------------------------------------------
module sorted_slotted_page_directory
    import ssp_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // timestamp[63:0], rec_len[75:64], replace[76], slot_index[84:77], zeros
    input  logic [87:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot[7:0], rec_offset[19:8], rec_len_out[31:20], timestamp_out[95:32],
    // replaced[96], compacted[97], record_count[106:98], free_bytes[118:107],
    // garbage_bytes[130:119], zeros
    output logic [135:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    localparam int PW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [PW-1:0] P_LAST = PW'(MAX_RECORDS - 1);
    localparam logic [11:0] FREE_INIT = 12'(PAGE_BYTES - HEAD_BYTES);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_COMPACT = 8'b0000_0100,
        S_SEARCH  = 8'b0000_1000,
        S_DECIDE  = 8'b0001_0000,
        S_WRITE   = 8'b0010_0000,
        S_READ    = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [PW-1:0] p_reg, p_next;
    logic [63:0]   ts_reg, ts_next;
    logic [11:0]   len_reg, len_next;
    logic          rep_reg, rep_next;
    logic [7:0]    sidx_reg, sidx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [11:0]   free_reg, free_next;
    logic [11:0]   garb_reg, garb_next;
    logic [12:0]   end_reg, end_next;
    logic [CW-1:0] less_reg, less_next;
    logic          eq_reg, eq_next;
    slot_t         fnd_reg, fnd_next;
    logic [11:0]   off_reg, off_next;
    slot_t         carry_reg, carry_next;
    res_t          res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_reg, out_next;

    slot_t         head;
    slot_t         tail;
    logic          shift;
    logic [CW-1:0] p_cnt;
    logic          in_use;
    logic          pass_end;
    logic [12:0]   need;
    logic [12:0]   room;
    logic [12:0]   end_cmp;
    logic [14:0]   fr;
    logic [13:0]   off_calc;

    // Chain of directory cells.
    ssp_ring #(.DEPTH(MAX_RECORDS)) u_ring
    (
        .clk   (clk),
        .shift (shift),
        .tail  (tail),
        .head  (head)
    );

    assign shift = (state_reg == S_COMPACT) || (state_reg == S_SEARCH) ||
                   (state_reg == S_WRITE) || (state_reg == S_READ);

    // Per-cycle helpers for the slot at the head.
    assign p_cnt    = CW'(p_reg);
    assign in_use   = p_cnt < count_reg;
    assign pass_end = p_reg == P_LAST;
    assign need     = {1'b0, len_reg} + 13'(REC_IDX_LEN);
    assign room     = {1'b0, free_reg} + {1'b0, garb_reg};
    assign end_cmp  = in_use ? end_reg - {1'b0, head.len} : end_reg;
    assign fr       = {2'b00, end_cmp} - 15'(HEAD_BYTES) - 15'({count_reg, 1'b0});
    assign off_calc = 14'(HEAD_BYTES) + 14'({count_reg, 1'b0}) + {2'b00, free_reg}
                      - {2'b00, len_reg};

    assign s_axis_tready = state_reg == S_IDLE;

    // Command sequencer and head logic.
    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        ts_next        = ts_reg;
        len_next       = len_reg;
        rep_next       = rep_reg;
        sidx_next      = sidx_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        garb_next      = garb_reg;
        end_next       = end_reg;
        less_next      = less_reg;
        eq_next        = eq_reg;
        fnd_next       = fnd_reg;
        off_next       = off_reg;
        carry_next     = carry_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_next       = out_reg;
        tail           = head;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ts_next   = s_axis_tdata[63:0];
                    len_next  = s_axis_tdata[75:64];
                    rep_next  = s_axis_tdata[76];
                    sidx_next = s_axis_tdata[84:77];
                    res_next  = '0;
                    p_next    = '0;
                    unique case (s_axis_tuser)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                            free_next  = FREE_INIT;
                            garb_next  = '0;
                            state_next = S_EMIT;
                        end
                        KIND_INSERT: state_next = S_CHECK;
                        KIND_READ:   state_next = S_READ;
                        default:     state_next = S_EMIT;
                    endcase
                end
            end

            S_CHECK:
            begin
                p_next = '0;
                if (({1'b0, free_reg} < need) && (room >= need))
                begin
                    res_next.compacted = 1'b1;
                    end_next           = 13'(PAGE_BYTES);
                    state_next         = S_COMPACT;
                end
                else if ({1'b0, free_reg} < need)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_EMIT;
                end
                else
                begin
                    less_next  = '0;
                    eq_next    = 1'b0;
                    state_next = S_SEARCH;
                end
            end

            // Repack records downward from the page end in slot order.
            S_COMPACT:
            begin
                end_next = end_cmp;
                if (in_use)
                begin
                    tail.off = end_cmp[11:0];
                end
                p_next = p_reg + 1'b1;
                if (pass_end)
                begin
                    free_next  = fr[14] ? 12'd0 : fr[11:0];
                    garb_next  = '0;
                    state_next = S_CHECK;
                end
            end

            // Count keys below the new one and look for an equal key.
            S_SEARCH:
            begin
                if (in_use)
                begin
                    if ($signed(head.key) < $signed(ts_reg))
                    begin
                        less_next = less_reg + 1'b1;
                    end
                    if (head.key == ts_reg)
                    begin
                        eq_next  = 1'b1;
                        fnd_next = head;
                    end
                end
                p_next = p_reg + 1'b1;
                if (pass_end)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                p_next = '0;
                if (eq_reg && !rep_reg)
                begin
                    res_next.status = ST_EXISTS;
                    res_next.slot   = 8'(less_reg);
                    res_next.off    = fnd_reg.off;
                    res_next.len    = fnd_reg.len;
                    res_next.key    = fnd_reg.key;
                    state_next      = S_EMIT;
                end
                else if (!eq_reg && (count_reg >= CW'(MAX_RECORDS)))
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_EMIT;
                end
                else
                begin
                    off_next   = off_calc[11:0];
                    state_next = S_WRITE;
                end
            end

            // Overwrite in place, or insert and ripple later entries up one.
            S_WRITE:
            begin
                if (p_cnt == less_reg)
                begin
                    tail.off = off_reg;
                    tail.len = len_reg;
                    tail.key = ts_reg;
                    carry_next = head;
                end
                else if (!eq_reg && (p_cnt > less_reg) && (p_cnt <= count_reg))
                begin
                    tail       = carry_reg;
                    carry_next = head;
                end
                p_next = p_reg + 1'b1;
                if (pass_end)
                begin
                    res_next.slot     = 8'(less_reg);
                    res_next.off      = off_reg;
                    res_next.len      = len_reg;
                    res_next.key      = ts_reg;
                    res_next.replaced = eq_reg;
                    if (eq_reg)
                    begin
                        garb_next = garb_reg + fnd_reg.len;
                        free_next = free_reg - len_reg;
                    end
                    else
                    begin
                        free_next  = free_reg - need[11:0];
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end

            S_READ:
            begin
                if ((9'(p_reg) == {1'b0, sidx_reg}) && in_use)
                begin
                    res_next.slot = sidx_reg;
                    res_next.off  = head.off;
                    res_next.len  = head.len;
                    res_next.key  = head.key;
                end
                p_next = p_reg + 1'b1;
                if (pass_end)
                begin
                    res_next.status = ({1'b0, sidx_reg} < 9'(count_reg)) ? ST_OK
                                                                          : ST_INVALID;
                    state_next = S_EMIT;
                end
            end

            // Hand the result to the output register once it is free.
            S_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_next         = res_reg;
                    out_next.count   = 9'(count_reg);
                    out_next.free    = free_reg;
                    out_next.garbage = garb_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control state and page counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            free_reg      <= FREE_INIT;
            garb_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            garb_reg      <= garb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current command.
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        ts_reg    <= ts_next;
        len_reg   <= len_next;
        rep_reg   <= rep_next;
        sidx_reg  <= sidx_next;
        end_reg   <= end_next;
        less_reg  <= less_next;
        eq_reg    <= eq_next;
        fnd_reg   <= fnd_next;
        off_reg   <= off_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // Output channel.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {5'b0, out_reg.garbage, out_reg.free, out_reg.count,
                            out_reg.compacted, out_reg.replaced, out_reg.key,
                            out_reg.len, out_reg.off, out_reg.slot};

    // The directory never holds more records than it has cells.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count beyond directory depth");

    // Page bytes are never double counted.
    a_space: assert property (@(posedge clk) disable iff (!rst_n)
        (14'(free_reg) + 14'(garb_reg) + 14'({count_reg, 1'b0}))
            <= 14'(PAGE_BYTES - HEAD_BYTES))
        else $error("free, garbage and slot bytes exceed page");

    // A write rotation ends in the result state.
    a_write_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) && pass_end |=> state_reg == S_EMIT)
        else $error("write rotation did not finish");

    // A clear empties the page at once.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_CLEAR)
            |=> (count_reg == '0) && (garb_reg == '0))
        else $error("clear did not empty the page");

endmodule

### tb/tb_sorted_slotted_page_directory.sv
// ---------------------------------------------------------------------------
// tb_sorted_slotted_page_directory: self-checking bench of the page directory
// A short table of directed commands runs first: page full, empty page,
// record exists, replace, compaction, invalid slot and the unused command.
// Random traffic follows: mixed commands, a run that fills the directory,
// and a final part with no idling. A behavioral copy of the directory predicts
// every result that the table does not give; each is compared field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_slotted_page_directory;
    import ssp_pkg::*;

    localparam int  DIR_SLOTS   = 256;
    localparam int  FREE_EMPTY  = PAGE_BYTES - HEAD_BYTES;
    localparam int  DRAIN_WAIT  = 3 * DIR_SLOTS + 40;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]  kind;
        logic [63:0] ts;
        logic [11:0] len;
        logic        rep;
        logic [7:0]  idx;
        bit          typed;
        res_t        want;
    } cmd_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // Shadow copy of the directory and its counters.
    logic [11:0] dir_off [DIR_SLOTS];
    logic [11:0] dir_len [DIR_SLOTS];
    logic [63:0] dir_key [DIR_SLOTS];
    int          rec_cnt;
    int          free_b;
    int          garb_b;

    res_t   pending_results[$];
    cmd_t   directed[$];
    bit     failed;
    bit     quiet;
    longint cycles;

    sorted_slotted_page_directory DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Signed ordering of two keys.
    function automatic int key_order(logic [63:0] a, logic [63:0] b);
        if ($signed(a) < $signed(b))
            return -1;
        if ($signed(a) > $signed(b))
            return 1;
        return 0;
    endfunction

    // Fills the record fields of a result from one directory entry.
    function automatic res_t with_slot(res_t r, int pos);
        r.slot = pos[7:0];
        r.off  = dir_off[pos];
        r.len  = dir_len[pos];
        r.key  = dir_key[pos];
        return r;
    endfunction

    // Applies one command to the shadow directory and returns its result.
    task automatic page_update(input cmd_t c, output res_t r);
        int need;
        int pos;
        int lo;
        int hi;
        int mid;
        int cmp;
        int stop;
        bit equal;
        logic [11:0] new_off;
        r     = '0;
        equal = 1'b0;
        pos   = 0;
        case (c.kind)
            KIND_CLEAR:
            begin
                rec_cnt = 0;
                free_b  = FREE_EMPTY;
                garb_b  = 0;
            end
            KIND_READ:
            begin
                if (c.idx < rec_cnt)
                    r = with_slot(r, c.idx);
                else
                    r.status = ST_INVALID;
            end
            KIND_INSERT:
            begin
                need = c.len + REC_IDX_LEN;
                // Repack the records downward from the page end in slot order.
                if (free_b < need && free_b + garb_b >= need)
                begin
                    stop = PAGE_BYTES;
                    for (int i = 0; i < rec_cnt; i++)
                    begin
                        stop       = stop - dir_len[i];
                        dir_off[i] = stop[11:0];
                    end
                    free_b = stop - HEAD_BYTES - rec_cnt * REC_IDX_LEN;
                    if (free_b < 0)
                        free_b = 0;
                    garb_b      = 0;
                    r.compacted = 1'b1;
                end
                if (free_b < need)
                    r.status = ST_FULL;
                else
                begin
                    // Compare with the last key, then binary search below it.
                    if (rec_cnt > 0)
                    begin
                        lo  = 0;
                        hi  = rec_cnt - 1;
                        mid = hi;
                        cmp = key_order(c.ts, dir_key[mid]);
                        if (cmp < 0)
                        begin
                            while (lo <= hi)
                            begin
                                mid = lo + (hi - lo) / 2;
                                cmp = key_order(c.ts, dir_key[mid]);
                                if (cmp == 0)
                                    break;
                                if (cmp > 0)
                                    lo = mid + 1;
                                else
                                    hi = mid - 1;
                            end
                        end
                        pos = mid;
                        if (cmp == 0)
                            equal = 1'b1;
                        else if (cmp > 0)
                            pos++;
                    end
                    if (equal && !c.rep)
                    begin
                        r.status = ST_EXISTS;
                        r = with_slot(r, pos);
                    end
                    else if (!equal && rec_cnt >= DIR_SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        new_off = 12'(HEAD_BYTES + rec_cnt * REC_IDX_LEN + free_b - c.len);
                        if (equal)
                        begin
                            garb_b       = garb_b + dir_len[pos];
                            dir_off[pos] = new_off;
                            dir_len[pos] = c.len;
                            free_b       = free_b - c.len;
                            r.replaced   = 1'b1;
                        end
                        else
                        begin
                            for (int i = rec_cnt; i > pos; i--)
                            begin
                                dir_off[i] = dir_off[i - 1];
                                dir_len[i] = dir_len[i - 1];
                                dir_key[i] = dir_key[i - 1];
                            end
                            dir_off[pos] = new_off;
                            dir_len[pos] = c.len;
                            dir_key[pos] = c.ts;
                            free_b       = free_b - need;
                            rec_cnt++;
                        end
                        r = with_slot(r, pos);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count   = rec_cnt[8:0];
        r.free    = free_b[11:0];
        r.garbage = garb_b[11:0];
    endtask

    // Drives one command and records its expected result on acceptance.
    task automatic send_cmd(input cmd_t c);
        res_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tuser  = c.kind;
        s_axis_tdata  = {3'b000, c.idx, c.rep, c.len, c.ts};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        page_update(c, r);
        pending_results.push_back(c.typed ? c.want : r);
        @(negedge clk);
    endtask

    function automatic cmd_t mk_cmd(logic [1:0] kind, logic [63:0] ts, logic [11:0] len,
                                    logic rep, logic [7:0] idx);
        cmd_t c;
        c.kind  = kind;
        c.ts    = ts;
        c.len   = len;
        c.rep   = rep;
        c.idx   = idx;
        c.typed = 1'b0;
        c.want  = '0;
        return c;
    endfunction

    function automatic cmd_t mk_typed(logic [1:0] kind, logic [63:0] ts, logic [11:0] len,
                                      logic [7:0] idx, res_t want);
        cmd_t c;
        c       = mk_cmd(kind, ts, len, 1'b0, idx);
        c.typed = 1'b1;
        c.want  = want;
        return c;
    endfunction

    // Random command; fill mode keeps records small to reach a full directory.
    function automatic cmd_t rand_cmd(bit fill);
        cmd_t        c;
        int          sel;
        logic [63:0] ts;
        ts  = {$urandom, $urandom};
        if (rec_cnt > 0 && $urandom_range(0, 9) < 3)
            ts = dir_key[$urandom_range(0, rec_cnt - 1)];
        sel = $urandom_range(0, 99);
        if (fill)
        begin
            if (sel < 94)
                c = mk_cmd(KIND_INSERT, (sel < 90) ? {$urandom, $urandom} : ts,
                           12'($urandom_range(0, 12)), 1'($urandom), 8'($urandom));
            else
                c = mk_cmd(KIND_READ, ts, 12'($urandom), 1'($urandom),
                           8'($urandom_range(0, 255)));
        end
        else if (sel < 3)
            c = mk_cmd(KIND_CLEAR, ts, 12'($urandom), 1'($urandom), 8'($urandom));
        else if (sel < 4)
            c = mk_cmd(KIND_UNUSED, ts, 12'($urandom), 1'($urandom), 8'($urandom));
        else if (sel < 70)
        begin
            sel = $urandom_range(0, 99);
            c = mk_cmd(KIND_INSERT, ts,
                       (sel < 80) ? 12'($urandom_range(1, 64)) :
                       (sel < 95) ? 12'($urandom_range(65, 1000)) : 12'($urandom),
                       1'($urandom), 8'($urandom));
        end
        else
            c = mk_cmd(KIND_READ, ts, 12'($urandom), 1'($urandom),
                       ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                       8'($urandom_range(0, rec_cnt + 1)));
        return c;
    endfunction

    // Reports one field that differs.
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // Result monitor: compares every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status    = m_axis_tuser;
            got.slot      = m_axis_tdata[7:0];
            got.off       = m_axis_tdata[19:8];
            got.len       = m_axis_tdata[31:20];
            got.key       = m_axis_tdata[95:32];
            got.replaced  = m_axis_tdata[96];
            got.compacted = m_axis_tdata[97];
            got.count     = m_axis_tdata[106:98];
            got.free      = m_axis_tdata[118:107];
            got.garbage   = m_axis_tdata[130:119];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %p", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("slot", want.slot, got.slot);
                check_field("rec_offset", want.off, got.off);
                check_field("rec_len_out", want.len, got.len);
                check_field("timestamp_out", want.key, got.key);
                check_field("replaced", want.replaced, got.replaced);
                check_field("compacted", want.compacted, got.compacted);
                check_field("record_count", want.count, got.count);
                check_field("free_bytes", want.free, got.free);
                check_field("garbage_bytes", want.garbage, got.garbage);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts, with occasional long open stretches.
    initial
    begin
        m_axis_tready = 1'b1;
        forever
        begin
            m_axis_tready = 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(100, 400)) @(negedge clk);
            else
                repeat ($urandom_range(1, 30)) @(negedge clk);
            if (!quiet)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
        end
    end

    // Stimulus: directed table, mixed traffic, directory fill, quiet tail.
    initial
    begin
        int wait_cycles;
        failed        = 1'b0;
        quiet         = 1'b0;
        cycles        = 0;
        rec_cnt       = 0;
        free_b        = FREE_EMPTY;
        garb_b        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_CLEAR;

        // Read on an empty page, unused command, oversized and page-filling records.
        directed.push_back(mk_typed(KIND_READ, 64'd0, 12'd0, 8'd0,
                                    '{ST_INVALID, 0, 0, 0, 0, 0, 0, 0,
                                      12'(FREE_EMPTY), 0}));
        directed.push_back(mk_typed(KIND_UNUSED, 64'd0, 12'd0, 8'd0,
                                    '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 12'(FREE_EMPTY), 0}));
        directed.push_back(mk_typed(KIND_INSERT, 64'h8000000000000000, 12'd4064, 8'd0,
                                    '{ST_FULL, 0, 0, 0, 0, 0, 0, 0, 12'(FREE_EMPTY), 0}));
        directed.push_back(mk_typed(KIND_INSERT, 64'd0, 12'd4062, 8'd0,
                                    '{ST_OK, 0, 34, 4062, 0, 0, 0, 1, 0, 0}));
        directed.push_back(mk_cmd(KIND_READ, 64'd0, 12'd0, 1'b0, 8'd0));
        directed.push_back(mk_cmd(KIND_INSERT, 64'd5, 12'd0, 1'b0, 8'd0));
        directed.push_back(mk_typed(KIND_CLEAR, 64'd0, 12'd0, 8'd0,
                                    '{ST_OK, 0, 0, 0, 0, 0, 0, 0, 12'(FREE_EMPTY), 0}));
        // Extreme keys and lengths, record exists, replace, then a compaction.
        directed.push_back(mk_cmd(KIND_INSERT, 64'h7FFFFFFFFFFFFFFF, 12'hFFF, 1'b1, 8'hFF));
        directed.push_back(mk_cmd(KIND_INSERT, 64'h8000000000000000, 12'd100, 1'b0, 8'd0));
        directed.push_back(mk_cmd(KIND_INSERT, 64'h7FFFFFFFFFFFFFFF, 12'd1, 1'b1, 8'd0));
        directed.push_back(mk_cmd(KIND_INSERT, 64'd0, 12'd300, 1'b0, 8'd0));
        directed.push_back(mk_cmd(KIND_INSERT, 64'd0, 12'd50, 1'b0, 8'd0));
        directed.push_back(mk_cmd(KIND_INSERT, 64'd0, 12'd60, 1'b1, 8'd0));
        directed.push_back(mk_cmd(KIND_INSERT, -64'sd5, 12'd200, 1'b0, 8'd0));
        directed.push_back(mk_cmd(KIND_INSERT, 64'd9, 12'd0, 1'b0, 8'd0));
        directed.push_back(mk_cmd(KIND_READ, 64'd0, 12'd0, 1'b0, 8'd255));
        directed.push_back(mk_cmd(KIND_READ, 64'd0, 12'd0, 1'b0, 8'd3));
        directed.push_back(mk_cmd(KIND_INSERT, 64'd7, 12'd3500, 1'b0, 8'd0));
        directed.push_back(mk_cmd(KIND_READ, 64'd0, 12'd0, 1'b0, 8'hAA));
        directed.push_back(mk_cmd(KIND_READ, 64'd0, 12'd0, 1'b0, 8'h55));
        directed.push_back(mk_cmd(KIND_READ, 64'd0, 12'd0, 1'b0, 8'd4));
        directed.push_back(mk_cmd(KIND_CLEAR, 64'd0, 12'd0, 1'b0, 8'd0));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_cmd(directed[i]);

        for (int i = 0; i < 150; i++)
            send_cmd(rand_cmd(1'b0));

        // Hold off until the page has answered everything, then fill the directory.
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        send_cmd(mk_cmd(KIND_CLEAR, {$urandom, $urandom}, 12'($urandom), 1'b0, 8'd0));
        for (int i = 0; i < 300; i++)
            send_cmd(rand_cmd(1'b1));

        // Last part runs with no idling on either side.
        quiet = 1'b1;
        for (int i = 0; i < 150; i++)
            send_cmd(rand_cmd(1'b0));
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        wait_cycles = DRAIN_WAIT;
        repeat (wait_cycles) @(negedge clk);

        if (!failed && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
